// ----- src/nmea_rmc_pkg.sv -----
package nmea_rmc_pkg;

    localparam int POS_W    = 7;
    localparam int COUNT_W  = 4;
    localparam int KNOTS_W  = 20;
    localparam int FACTOR_W = 10;
    localparam int PROD_W   = KNOTS_W + FACTOR_W;
    localparam int SPEED_W  = 24;
    localparam int FRAC_W   = 2;

    localparam logic [KNOTS_W-1:0]  KNOTS_MAX      = '1;
    localparam logic [FACTOR_W-1:0] FACTOR_DEFAULT = 10'd185;

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 2**PROD_W
    localparam int                RECIP_SHIFT = 37;
    localparam int                RECIP_W     = 31;
    localparam logic [RECIP_W-1:0] RECIP_100  = 31'd1374389535;

    localparam logic [POS_W-1:0] POS_IDLE      = 7'd0;
    localparam logic [POS_W-1:0] POS_FIRST     = 7'd2;
    localparam logic [POS_W-1:0] POS_HDR_LAST  = 7'd6;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_POINT  = 8'h2E;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_M      = 8'h4D;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_P      = 8'h50;
    localparam logic [7:0] CH_R      = 8'h52;
    localparam logic [7:0] CH_V      = 8'h56;

    localparam logic [COUNT_W-1:0] FLD_STATUS = 4'd2;
    localparam logic [COUNT_W-1:0] FLD_LAT    = 4'd3;
    localparam logic [COUNT_W-1:0] FLD_NS     = 4'd4;
    localparam logic [COUNT_W-1:0] FLD_LON    = 4'd5;
    localparam logic [COUNT_W-1:0] FLD_EW     = 4'd6;
    localparam logic [COUNT_W-1:0] FLD_SPEED  = 4'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 4'd15;

    localparam logic [1:0] FID_LAT   = 2'd0;
    localparam logic [1:0] FID_LON   = 2'd1;
    localparam logic [1:0] FID_SPEED = 2'd2;

    localparam logic [FRAC_W-1:0] FRAC_DONE = 2'd3;

    typedef struct packed {
        logic       sentence_end;
        logic [1:0] field_id;
        logic [7:0] char_value;
        logic       fix_valid;
        logic       north;
        logic       east;
    } res_t;

    function automatic logic [7:0] hdr_char(input logic [POS_W-1:0] pos);
        logic [7:0] c;
        unique case (pos)
            7'd2:    c = CH_G;
            7'd3:    c = CH_P;
            7'd4:    c = CH_R;
            7'd5:    c = CH_M;
            7'd6:    c = CH_C;
            default: c = CH_DOLLAR;
        endcase
        return c;
    endfunction

endpackage

// ----- src/nmea_rmc_parse.sv -----
module nmea_rmc_parse #(
    parameter int MAX_POSITION = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [7:0]                     rx_byte,
    input  logic [nmea_rmc_pkg::FACTOR_W-1:0] speed_factor,
    output logic                           res_valid,
    output nmea_rmc_pkg::res_t             res,
    output logic [nmea_rmc_pkg::PROD_W-1:0] prod
);
    import nmea_rmc_pkg::*;

    logic [POS_W-1:0]   pos_reg,      pos_next;
    logic               hdr_reg,      hdr_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic               fix_reg,      fix_next;
    logic               north_reg,    north_next;
    logic               east_reg,     east_next;
    logic [KNOTS_W-1:0] knots_reg,    knots_next;
    logic [FRAC_W-1:0]  frac_reg,     frac_next;
    logic               point_reg,    point_next;

    logic               is_digit;
    logic [3:0]         digit;
    logic [24:0]        int_sum;
    logic [6:0]         frac_weight;
    logic [9:0]         frac_add;
    logic [KNOTS_W:0]   frac_sum;
    logic [COUNT_W-1:0] count_inc;

    assign is_digit  = (rx_byte >= CH_0) && (rx_byte <= CH_9);
    assign digit     = 4'(rx_byte - CH_0);
    assign int_sum   = (25'(knots_reg) << 3) + (25'(knots_reg) << 1)
                     + 25'(14'(digit) * 14'd1000);
    assign frac_add  = 10'(10'(digit) * 10'(frac_weight));
    assign frac_sum  = (KNOTS_W+1)'(knots_reg) + (KNOTS_W+1)'(frac_add);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + 4'd1;

    always_comb
    begin
        unique case (frac_reg)
            2'd0:    frac_weight = 7'd100;
            2'd1:    frac_weight = 7'd10;
            2'd2:    frac_weight = 7'd1;
            default: frac_weight = 7'd0;
        endcase
    end

    always_comb
    begin
        pos_next   = pos_reg;
        hdr_next   = hdr_reg;
        count_next = count_reg;
        fix_next   = fix_reg;
        north_next = north_reg;
        east_next  = east_reg;
        knots_next = knots_reg;
        frac_next  = frac_reg;
        point_next = point_reg;
        res_valid  = 1'b0;
        res        = '0;
        prod       = '0;

        priority if (rx_byte == CH_DOLLAR)
        begin
            hdr_next   = 1'b0;
            count_next = '0;
            fix_next   = 1'b0;
            north_next = 1'b0;
            east_next  = 1'b0;
            knots_next = '0;
            frac_next  = '0;
            point_next = 1'b0;
            pos_next   = POS_FIRST;
        end
        else if (pos_reg == POS_IDLE)
        begin
        end
        else if (!hdr_reg)
        begin
            if (rx_byte != hdr_char(pos_reg))
            begin
                pos_next = POS_IDLE;
            end
            else
            begin
                pos_next = pos_reg + 7'd1;
                hdr_next = (pos_reg == POS_HDR_LAST);
            end
        end
        else if (rx_byte == CH_STAR)
        begin
            res_valid        = 1'b1;
            res.sentence_end = 1'b1;
            res.field_id     = FID_SPEED;
            res.fix_valid    = fix_reg;
            res.north        = fix_reg && north_reg;
            res.east         = fix_reg && east_reg;
            prod             = fix_reg ? PROD_W'(knots_reg) * PROD_W'(speed_factor) : '0;
            pos_next   = POS_IDLE;
            hdr_next   = 1'b0;
            count_next = '0;
            fix_next   = 1'b0;
            north_next = 1'b0;
            east_next  = 1'b0;
            knots_next = '0;
            frac_next  = '0;
            point_next = 1'b0;
        end
        else if (pos_reg >= POS_W'(MAX_POSITION))
        begin
        end
        else
        begin
            pos_next = pos_reg + 7'd1;
            if (rx_byte == CH_COMMA)
            begin
                count_next = count_inc;
                point_next = 1'b0;
                if (count_inc == FLD_STATUS)
                    fix_next = 1'b1;
                else if (count_inc == FLD_NS)
                    north_next = 1'b0;
                else if (count_inc == FLD_EW)
                    east_next = 1'b0;
                else if (count_inc == FLD_SPEED)
                begin
                    knots_next = '0;
                    frac_next  = '0;
                end
            end
            else
            begin
                unique case (count_reg)
                    FLD_STATUS:
                    begin
                        if (!point_reg)
                        begin
                            if (rx_byte == CH_V)
                                fix_next = 1'b0;
                            point_next = 1'b1;
                        end
                    end
                    FLD_NS:
                    begin
                        if (!point_reg)
                        begin
                            north_next = (rx_byte == CH_N);
                            point_next = 1'b1;
                        end
                    end
                    FLD_EW:
                    begin
                        if (!point_reg)
                        begin
                            east_next  = (rx_byte == CH_E);
                            point_next = 1'b1;
                        end
                    end
                    FLD_LAT, FLD_LON:
                    begin
                        if (fix_reg)
                        begin
                            res_valid      = 1'b1;
                            res.field_id   = (count_reg == FLD_LAT) ? FID_LAT : FID_LON;
                            res.char_value = rx_byte;
                        end
                    end
                    FLD_SPEED:
                    begin
                        if (is_digit)
                        begin
                            if (!point_reg)
                            begin
                                knots_next = (int_sum > 25'(KNOTS_MAX)) ? KNOTS_MAX
                                                                         : int_sum[KNOTS_W-1:0];
                            end
                            else if (frac_reg != FRAC_DONE)
                            begin
                                knots_next = frac_sum[KNOTS_W] ? KNOTS_MAX
                                                               : frac_sum[KNOTS_W-1:0];
                                frac_next  = frac_reg + 2'd1;
                            end
                        end
                        else if (rx_byte == CH_POINT && !point_reg)
                        begin
                            point_next = 1'b1;
                        end
                        else
                        begin
                            point_next = 1'b1;
                            frac_next  = FRAC_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_IDLE;
            hdr_reg   <= 1'b0;
            count_reg <= '0;
            fix_reg   <= 1'b0;
            north_reg <= 1'b0;
            east_reg  <= 1'b0;
            knots_reg <= '0;
            frac_reg  <= '0;
            point_reg <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            hdr_reg   <= hdr_next;
            count_reg <= count_next;
            fix_reg   <= fix_next;
            north_reg <= north_next;
            east_reg  <= east_next;
            knots_reg <= knots_next;
            frac_reg  <= frac_next;
            point_reg <= point_next;
        end
    end

endmodule

// ----- src/nmea_rmc_field_extractor_top.sv -----
// Byte-wide $GPRMC parser. One byte is accepted per clock while the output
// side keeps up: the byte lands in an input register, the parser updates its
// sentence state and forms any result, the knots-times-factor product is
// registered, and the divide by 100 (a reciprocal multiply) fills the output
// register. A byte that makes no result never waits on the output.
// Latitude and longitude characters leave as character beats while the fix
// is valid, and '*' after a good header yields the summary beat.
// speed_factor may be rewritten only while no beat is in flight.
module nmea_rmc_field_extractor_top #(
    parameter int MAX_POSITION = 100
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [nmea_rmc_pkg::FACTOR_W-1:0]  speed_factor,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         rx_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               sentence_end,
    output logic [1:0]                         field_id,
    output logic [7:0]                         char_value,
    output logic                               fix_valid,
    output logic                               north,
    output logic                               east,
    output logic [nmea_rmc_pkg::SPEED_W-1:0]   speed_kmh_milli
);
    import nmea_rmc_pkg::*;

    logic [FACTOR_W-1:0] factor_reg;

    logic                s0_valid_reg, s0_valid_next;
    logic [7:0]          s0_byte_reg;
    logic                s0_go;

    logic                res_valid;
    res_t                res;
    logic [PROD_W-1:0]   prod;

    logic                s1_valid_reg, s1_valid_next;
    res_t                s1_res_reg;
    logic [PROD_W-1:0]   s1_prod_reg;
    logic                s1_go;

    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg;
    logic [SPEED_W-1:0]  out_speed_reg;

    logic [PROD_W+RECIP_W-1:0] scaled;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            factor_reg <= FACTOR_DEFAULT;
        else if (cfg_valid && cfg_ready)
            factor_reg <= speed_factor;
    end

    nmea_rmc_parse #(
        .MAX_POSITION (MAX_POSITION)
    ) u_parse (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (s0_go),
        .rx_byte      (s0_byte_reg),
        .speed_factor (factor_reg),
        .res_valid    (res_valid),
        .res          (res),
        .prod         (prod)
    );

    assign s1_go = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s0_go = s0_valid_reg && (!res_valid || !s1_valid_reg || s1_go);

    assign in_stall = s0_valid_reg && !s0_go;

    always_comb
    begin
        s0_valid_next = s0_valid_reg;
        if (in_valid && !in_stall)
            s0_valid_next = 1'b1;
        else if (s0_go)
            s0_valid_next = 1'b0;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s0_go && res_valid)
            s1_valid_next = 1'b1;
        else if (s1_go)
            s1_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_go)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    assign scaled = (PROD_W+RECIP_W)'(s1_prod_reg) * (PROD_W+RECIP_W)'(RECIP_100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_valid_reg  <= s0_valid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            s0_byte_reg <= rx_byte;
        if (s0_go && res_valid)
        begin
            s1_res_reg  <= res;
            s1_prod_reg <= prod;
        end
        if (s1_go)
        begin
            out_res_reg   <= s1_res_reg;
            out_speed_reg <= scaled[RECIP_SHIFT +: SPEED_W];
        end
    end

    assign out_valid       = out_valid_reg;
    assign sentence_end    = out_res_reg.sentence_end;
    assign field_id        = out_res_reg.field_id;
    assign char_value      = out_res_reg.char_value;
    assign fix_valid       = out_res_reg.fix_valid;
    assign north           = out_res_reg.north;
    assign east            = out_res_reg.east;
    assign speed_kmh_milli = out_speed_reg;

    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sentence_end |-> field_id == FID_SPEED && char_value == 8'd0)
        else $error("summary beat carries a character");

    a_char_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !sentence_end |->
            !fix_valid && !north && !east && speed_kmh_milli == '0
            && field_id != FID_SPEED)
        else $error("character beat carries summary fields");

    a_nofix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sentence_end && !fix_valid |->
            !north && !east && speed_kmh_milli == '0)
        else $error("summary without fix reports position data");

    a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid && out_stall |=> s1_valid_reg)
        else $error("middle stage dropped a beat");

endmodule

// ----- tb/sv/nmea_rmc_field_extractor_top_test.sv -----
`default_nettype none

module nmea_rmc_field_extractor_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import nmea_rmc_pkg::*;

    localparam int LONG_LIMIT = 100;
    localparam logic [SPEED_W-1:0] SPEED_SAT = '1;

    localparam logic [7:0] HEADER_TAIL [5] = '{CH_G, CH_P, CH_R, CH_M, CH_C};

    typedef struct packed {
        logic               sentence_end;
        logic [1:0]         field_id;
        logic [7:0]         char_value;
        logic               fix_valid;
        logic               north;
        logic               east;
        logic [SPEED_W-1:0] speed;
    } rmc_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [FACTOR_W-1:0] speed_factor = FACTOR_DEFAULT;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                sentence_end;
    logic [1:0]          field_id;
    logic [7:0]          char_value;
    logic                fix_valid;
    logic                north;
    logic                east;
    logic [SPEED_W-1:0]  speed_kmh_milli;

    nmea_rmc_field_extractor_top #(
        .MAX_POSITION(LONG_LIMIT)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .speed_factor(speed_factor),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .rx_byte(rx_byte),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .sentence_end(sentence_end),
        .field_id(field_id),
        .char_value(char_value),
        .fix_valid(fix_valid),
        .north(north),
        .east(east),
        .speed_kmh_milli(speed_kmh_milli)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    logic [7:0] rx_stream [$];
    logic [7:0] draft [$];
    rmc_beat_t  expected_beats [$];

    int bytes_owed = 0;
    int bytes_sent = 0;
    int sentences = 0;
    int factor_settings = 1;
    int char_beats = 0;
    int summary_beats = 0;
    int errors = 0;
    int idle_mode = 0;
    int tx_gap = 0;
    int rx_gap = 0;

    logic [FACTOR_W-1:0] rmc_factor = FACTOR_DEFAULT;
    logic [POS_W-1:0]    rmc_pos = POS_IDLE;
    logic                rmc_header_ok = 1'b0;
    logic [COUNT_W-1:0]  rmc_commas = '0;
    logic                rmc_fix = 1'b0;
    logic                rmc_north = 1'b0;
    logic                rmc_east = 1'b0;
    logic [KNOTS_W-1:0]  rmc_knots = '0;
    logic [FRAC_W-1:0]   rmc_frac = '0;
    logic                rmc_first_taken = 1'b0;

    function automatic void drop_sentence();
        rmc_pos = POS_IDLE;
        rmc_header_ok = 1'b0;
        rmc_commas = '0;
        rmc_fix = 1'b0;
        rmc_north = 1'b0;
        rmc_east = 1'b0;
        rmc_knots = '0;
        rmc_frac = '0;
        rmc_first_taken = 1'b0;
    endfunction

    task automatic accumulate_speed(input logic [7:0] b);
        logic [31:0] digit;
        logic [31:0] add;
        digit = 32'(b - CH_0);
        if (b >= CH_0 && b <= CH_9)
        begin
            if (!rmc_first_taken)
            begin
                if (32'(rmc_knots) > (32'(KNOTS_MAX) - digit * 1000) / 10)
                    rmc_knots = KNOTS_MAX;
                else
                    rmc_knots = KNOTS_W'(32'(rmc_knots) * 10 + digit * 1000);
            end
            else if (rmc_frac < FRAC_DONE)
            begin
                add = digit * ((rmc_frac == 0) ? 100 : (rmc_frac == 1) ? 10 : 1);
                if (32'(rmc_knots) > 32'(KNOTS_MAX) - add)
                    rmc_knots = KNOTS_MAX;
                else
                    rmc_knots = KNOTS_W'(32'(rmc_knots) + add);
                rmc_frac++;
            end
        end
        else if (b == CH_POINT && !rmc_first_taken)
            rmc_first_taken = 1'b1;
        else
        begin
            rmc_first_taken = 1'b1;
            rmc_frac = FRAC_DONE;
        end
    endtask

    task automatic parse_rx_byte(input logic [7:0] b);
        rmc_beat_t   beat;
        logic [63:0] scaled;
        beat = '0;
        if (b == CH_DOLLAR)
        begin
            drop_sentence();
            rmc_pos = POS_FIRST;
            return;
        end
        if (rmc_pos == POS_IDLE)
            return;
        if (!rmc_header_ok)
        begin
            if (rmc_pos < POS_FIRST || rmc_pos > POS_HDR_LAST
                    || b != HEADER_TAIL[rmc_pos - POS_FIRST])
                drop_sentence();
            else
            begin
                rmc_pos++;
                if (rmc_pos == POS_HDR_LAST + 1)
                    rmc_header_ok = 1'b1;
            end
            return;
        end
        if (b == CH_STAR)
        begin
            beat.sentence_end = 1'b1;
            beat.field_id = FID_SPEED;
            if (rmc_fix)
            begin
                scaled = 64'(rmc_knots) * 64'(rmc_factor) / 100;
                beat.speed = (scaled > 64'(SPEED_SAT)) ? SPEED_SAT : scaled[SPEED_W-1:0];
                beat.fix_valid = 1'b1;
                beat.north = rmc_north;
                beat.east = rmc_east;
            end
            expected_beats.push_back(beat);
            drop_sentence();
            return;
        end
        if (rmc_pos >= LONG_LIMIT)
            return;
        rmc_pos++;
        if (b == CH_COMMA)
        begin
            if (rmc_commas != COUNT_MAX)
                rmc_commas++;
            rmc_first_taken = 1'b0;
            case (rmc_commas)
                FLD_STATUS: rmc_fix = 1'b1;
                FLD_NS:     rmc_north = 1'b0;
                FLD_EW:     rmc_east = 1'b0;
                FLD_SPEED:
                begin
                    rmc_knots = '0;
                    rmc_frac = '0;
                end
                default: ;
            endcase
            return;
        end
        case (rmc_commas)
            FLD_STATUS:
                if (!rmc_first_taken)
                begin
                    if (b == CH_V)
                        rmc_fix = 1'b0;
                    rmc_first_taken = 1'b1;
                end
            FLD_NS:
                if (!rmc_first_taken)
                begin
                    rmc_north = (b == CH_N);
                    rmc_first_taken = 1'b1;
                end
            FLD_EW:
                if (!rmc_first_taken)
                begin
                    rmc_east = (b == CH_E);
                    rmc_first_taken = 1'b1;
                end
            FLD_LAT, FLD_LON:
                if (rmc_fix)
                begin
                    beat.field_id = (rmc_commas == FLD_LAT) ? FID_LAT : FID_LON;
                    beat.char_value = b;
                    expected_beats.push_back(beat);
                end
            FLD_SPEED: accumulate_speed(b);
            default: ;
        endcase
    endtask

    function automatic int idle_odds();
        return (idle_mode == 2) ? 3 : 11;
    endfunction

    always @(posedge clk)
    begin : byte_driver
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                parse_rx_byte(rx_byte);
                bytes_owed--;
            end
            // hold a stalled beat
            if (!(in_valid && in_stall))
            begin
                if (tx_gap > 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap--;
                end
                else if (rx_stream.size() != 0 && idle_mode != 0
                        && $urandom_range(0, idle_odds()) == 0)
                begin
                    in_valid <= 1'b0;
                    tx_gap = $urandom_range(0, 12);
                end
                else if (rx_stream.size() != 0)
                begin
                    in_valid <= 1'b1;
                    rx_byte <= rx_stream.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    function automatic void match_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin : beat_monitor
        rmc_beat_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected");
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    match_field("sentence_end", 32'(want.sentence_end), 32'(sentence_end));
                    match_field("field_id", 32'(want.field_id), 32'(field_id));
                    match_field("char_value", 32'(want.char_value), 32'(char_value));
                    match_field("fix_valid", 32'(want.fix_valid), 32'(fix_valid));
                    match_field("north", 32'(want.north), 32'(north));
                    match_field("east", 32'(want.east), 32'(east));
                    match_field("speed_kmh_milli", 32'(want.speed), 32'(speed_kmh_milli));
                    if (want.sentence_end)
                        summary_beats++;
                    else
                        char_beats++;
                end
            end
            if (rx_gap > 0)
            begin
                out_stall <= 1'b1;
                rx_gap--;
            end
            else if (idle_mode != 0 && $urandom_range(0, idle_odds()) == 0)
            begin
                out_stall <= 1'b1;
                rx_gap = $urandom_range(0, 12);
            end
            else
                out_stall <= 1'b0;
        end
    end

    function automatic void push_byte(input logic [7:0] b, input bit counted);
        rx_stream.push_back(b);
        bytes_owed++;
        if (counted)
            bytes_sent++;
        if (b == CH_DOLLAR)
            sentences++;
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], 1'b1);
    endfunction

    function automatic logic [7:0] field_char();
        logic [7:0] b;
        if ($urandom_range(0, 9) < 7)
            return ($urandom_range(0, 10) == 10) ? CH_POINT : 8'(CH_0 + $urandom_range(0, 9));
        do
            b = 8'($urandom_range(0, 255));
        while (b == CH_DOLLAR || b == CH_STAR || b == CH_COMMA);
        return b;
    endfunction

    function automatic void draft_digits(input int n);
        repeat (n) draft.push_back(8'(CH_0 + $urandom_range(0, 9)));
    endfunction

    function automatic void draft_chars(input int n);
        repeat (n) draft.push_back(field_char());
    endfunction

    function automatic void draft_position();
        if ($urandom_range(0, 14) == 0)
            draft_chars($urandom_range(40, 95));
        else
            draft_chars($urandom_range(0, 10));
    endfunction

    function automatic void draft_hemisphere(input logic [7:0] yes, input logic [7:0] no);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            draft.push_back($urandom_range(0, 1) ? yes : no);
        else if (r > 7)
            draft_chars($urandom_range(1, 2));
    endfunction

    function automatic void queue_sentence();
        int r;
        int cut;
        logic [7:0] b;
        draft.delete();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4))
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_DOLLAR);
                push_byte(b, 1'b1);
            end
        push_byte(CH_DOLLAR, 1'b1);
        if ($urandom_range(0, 19) == 0)
        begin
            cut = $urandom_range(0, 4);
            for (int i = 0; i < cut; i++)
                push_byte(HEADER_TAIL[i], 1'b1);
            do
                b = 8'($urandom_range(0, 255));
            while (b == CH_DOLLAR || b == HEADER_TAIL[cut]);
            push_byte(b, 1'b1);
            repeat ($urandom_range(0, 5)) push_byte(field_char(), 1'b1);
            return;
        end
        push_text("GPRMC");
        draft.push_back(CH_COMMA);
        draft_digits($urandom_range(0, 6));
        draft.push_back(CH_COMMA);
        r = $urandom_range(0, 9);
        if (r < 5)
            draft.push_back(8'h41);
        else if (r < 8)
            draft.push_back(CH_V);
        else if (r == 9)
            draft_chars($urandom_range(1, 3));
        draft.push_back(CH_COMMA);
        draft_position();
        draft.push_back(CH_COMMA);
        draft_hemisphere(CH_N, 8'h53);
        draft.push_back(CH_COMMA);
        draft_position();
        draft.push_back(CH_COMMA);
        draft_hemisphere(CH_E, 8'h57);
        draft.push_back(CH_COMMA);
        draft_digits(($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(0, 3));
        if ($urandom_range(0, 3) != 0)
        begin
            draft.push_back(CH_POINT);
            draft_digits($urandom_range(0, 5));
        end
        if ($urandom_range(0, 7) == 0)
        begin
            draft.push_back(field_char());
            draft_digits($urandom_range(0, 3));
        end
        repeat (($urandom_range(0, 9) == 0) ? 10 : $urandom_range(0, 3))
        begin
            draft.push_back(CH_COMMA);
            draft_digits($urandom_range(0, 6));
        end
        r = $urandom_range(0, 9);
        cut = (r < 2) ? $urandom_range(0, draft.size()) : draft.size();
        for (int i = 0; i < cut; i++)
            push_byte(draft[i], 1'b1);
        if (r == 0)
            return;
        push_byte(CH_STAR, 1'b1);
        if ($urandom_range(0, 3) == 0)
        begin
            push_byte(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
            push_byte(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
            push_byte(8'h0D, 1'b0);
            push_byte(8'h0A, 1'b0);
        end
    endfunction

    task automatic wait_drained();
        while (bytes_owed != 0 || expected_beats.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_factor(input logic [FACTOR_W-1:0] value);
        cfg_valid <= 1'b1;
        speed_factor <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        rmc_factor = value;
        factor_settings++;
    endtask

    initial
    begin : stimulus
        logic [FACTOR_W-1:0] factors [6];
        int target;
        factors[0] = '0;
        factors[1] = '1;
        factors[2] = FACTOR_W'($urandom_range(2, 1022));
        factors[3] = FACTOR_W'(1);
        factors[4] = FACTOR_W'($urandom_range(0, 1023));
        factors[5] = FACTOR_W'(100);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        idle_mode = 1;

        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("$GPX,1");
        push_text("$G*");
        push_text("$GPRMC*");
        push_text("$GPRMC,1,V,45,N,7,E,3.5*");
        push_text("$GPRMC,,,");
        push_byte(8'h00, 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text(",N,9,E,1.2345.6*");
        push_text("$GPRMC,,A,1,S,2,W,9999999*");
        push_text("$GPRMC,,A,1$GPRMC,,A,2,N,,E,1.5x7*");

        for (int phase = 0; phase < 6; phase++)
        begin
            wait_drained();
            write_factor(factors[phase]);
            idle_mode = (phase == 5) ? 0 : (phase % 3);
            target = bytes_sent + 125;
            while (bytes_sent < target)
                queue_sentence();
        end

        while (bytes_owed != 0)
            @(posedge clk);
        for (int n = 0; n < 200 && expected_beats.size() != 0; n++)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (expected_beats.size() != 0)
        begin
            $error("%0d expected beats never arrived", expected_beats.size());
            errors++;
        end

        $display("Drove %0d bytes in %0d sentence starts under %0d speed factors.",
                 bytes_sent, sentences, factor_settings);
        $display("Checked %0d position character beats and %0d sentence summaries.",
                 char_beats, summary_beats);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #400_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- nmea_rmc_field_extractor_top.f -----
src/nmea_rmc_pkg.sv
src/nmea_rmc_parse.sv
src/nmea_rmc_field_extractor_top.sv
tb/sv/nmea_rmc_field_extractor_top_test.sv
